FILE: hdl/cfhu_pkg.sv
// ----------------------------------------------------------------------------
// cfhu_pkg
// shared types and constants of the circular fault height map block
// ----------------------------------------------------------------------------
`default_nettype none

package cfhu_pkg;

   localparam int FRAC_BITS = 8;
   localparam int MAX_DIM   = 256;
   localparam int ADDR_W    = 16;
   localparam int H_W       = 24;
   localparam int SQ_STEPS  = 18;
   localparam int SQ_W      = 36;
   localparam int RECIP3    = 43691;
   localparam int RECIP_SH  = 17;

   localparam logic [1:0] FUNC_FAULT = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_FAULT   = 2'd0;
   localparam logic [1:0] STATUS_READ    = 2'd1;
   localparam logic [1:0] STATUS_CLEAR   = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   localparam logic [2:0] CSR_WIDTH   = 3'd0;
   localparam logic [2:0] CSR_HEIGHT  = 3'd1;
   localparam logic [2:0] CSR_THRESH  = 3'd2;
   localparam logic [2:0] CSR_CEILING = 3'd3;
   localparam logic [2:0] CSR_FLOOR   = 3'd4;

   localparam logic [8:0]        WIDTH_RST   = 9'd256;
   localparam logic [8:0]        HEIGHT_RST  = 9'd256;
   localparam logic [7:0]        THRESH_RST  = 8'd7;
   localparam logic signed [15:0] CEILING_RST = 16'sd500;
   localparam logic signed [15:0] FLOOR_RST   = -16'sd500;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_CLEAR, S_READ, S_RDATA,
      S_SETUP, S_SETUP2, S_SCAN, S_DRAIN, S_DONE
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/circular_fault_heightmap_update.sv
// fault: scans all 65536 cells, one cell a cycle through the distance and sqrt pipeline
// read: one registered memory read; clear: a write sweep that zeroes every cell
// one transaction at a time; the next is taken while a result waits in the output register
// after reset a clearing sweep zeroes all 65536 cells of the store; req_stall stays high meanwhile
// ----------------------------------------------------------------------------
// circular_fault_heightmap_update
// toroidal height map updated by circular faults, with cell read and clear
// ----------------------------------------------------------------------------
`default_nettype none

module circular_fault_heightmap_update import cfhu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [15:0]             req_center_x,
   input  logic [15:0]             req_center_y,
   input  logic                    req_lower_inside,
   input  logic [7:0]              req_cell_x,
   input  logic [7:0]              req_cell_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [23:0]      rsp_height,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata
);

   // configuration
   logic [8:0]         width_ff, height_ff;
   logic [7:0]         thresh_ff;
   logic signed [15:0] ceiling_ff, floor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RST;
         height_ff  <= HEIGHT_RST;
         thresh_ff  <= THRESH_RST;
         ceiling_ff <= CEILING_RST;
         floor_ff   <= FLOOR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH:   width_ff   <= csr_wdata[8:0];
            CSR_HEIGHT:  height_ff  <= csr_wdata[8:0];
            CSR_THRESH:  thresh_ff  <= csr_wdata[7:0];
            CSR_CEILING: ceiling_ff <= csr_wdata;
            CSR_FLOOR:   floor_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [8:0]  w_eff, h_eff, mn;
   logic [15:0] thr_q;
   logic [16:0] span_x, span_y;

   always_comb begin
      w_eff = (width_ff == 9'd0) ? 9'd1 : ((width_ff > 9'(MAX_DIM)) ? 9'(MAX_DIM) : width_ff);
      h_eff = (height_ff == 9'd0) ? 9'd1 :
              ((height_ff > 9'(MAX_DIM)) ? 9'(MAX_DIM) : height_ff);
      mn     = (w_eff < h_eff) ? w_eff : h_eff;
      thr_q  = {thresh_ff, {FRAC_BITS{1'b0}}};
      span_x = {w_eff, {FRAC_BITS{1'b0}}};
      span_y = {h_eff, {FRAC_BITS{1'b0}}};
   end

   // control state
   state_type   state_ff, state_in;
   logic [16:0] cnt_ff, cnt_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic signed [23:0] res_height_ff, res_height_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic signed [23:0] rsp_height_ff;
   logic        ld_rsp, issue, busy, accept;

   // transaction fields
   logic [15:0] cx_ff, cy_ff;
   logic        lower_ff;
   logic [7:0]  rx_ff, ry_ff;

   // fault constants
   logic [14:0] radius_ff;
   logic [29:0] r2_ff;
   logic [17:0] limit_ff;
   logic [33:0] r_prod;

   assign r_prod = {mn, {FRAC_BITS{1'b0}}} * 17'(RECIP3);

   // memory
   logic [H_W-1:0]    mem [0:(1 << ADDR_W)-1];
   logic [H_W-1:0]    mem_rd_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [H_W-1:0]    mem_wdata, upd_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_raddr];
   end

   // pipeline
   logic                    a_vld_ff, b_vld_ff, e_vld_ff;
   logic signed [17:0]      a_dx_ff, a_dy_ff;
   logic [ADDR_W-1:0]       a_addr_ff, b_addr_ff, e_addr_ff;
   logic                    a_map_ff, b_map_ff, e_map_ff;
   logic [33:0]             b_dx2_ff, b_dy2_ff;
   logic signed [35:0]      sq_x, sq_y;
   logic [SQ_STEPS:0]       q_vld_ff;
   logic [SQ_W-1:0]         q_v_ff   [0:SQ_STEPS];
   logic [SQ_W-1:0]         q_r_ff   [0:SQ_STEPS];
   logic [ADDR_W-1:0]       q_addr_ff[0:SQ_STEPS];
   logic                    q_in_ff  [0:SQ_STEPS];
   logic                    q_map_ff [0:SQ_STEPS];
   logic                    e_in_ff;
   logic [15:0]             e_amt_ff;
   logic [34:0]             d2;
   logic [17:0]             sqrt_val, rim;
   logic signed [18:0]      rim_d;
   logic [15:0]             amt;
   logic [7:0]              ix, iy;
   logic signed [17:0]      wx, wy;

   function automatic logic signed [17:0] wrap_axis(input logic [7:0] idx,
                                                    input logic [15:0] ctr,
                                                    input logic [17:0] lim,
                                                    input logic [16:0] span);
      logic signed [17:0] d;
      logic [16:0]        ad;
      d  = $signed({2'b00, idx, {FRAC_BITS{1'b0}}}) - $signed({2'b00, ctr});
      ad = d[17] ? 17'(-d) : 17'(d);
      if ({1'b0, ad} > lim) begin
         wrap_axis = d[17] ? d + $signed({1'b0, span}) : d - $signed({1'b0, span});
      end else begin
         wrap_axis = d;
      end
   endfunction

   assign ix = cnt_ff[7:0];
   assign iy = cnt_ff[15:8];
   assign wx = wrap_axis(ix, cx_ff, limit_ff, span_x);
   assign wy = wrap_axis(iy, cy_ff, limit_ff, span_y);
   assign sq_x = a_dx_ff * a_dx_ff;
   assign sq_y = a_dy_ff * a_dy_ff;
   assign d2 = 35'(b_dx2_ff) + 35'(b_dy2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         q_vld_ff <= '0;
         e_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= issue;
         b_vld_ff <= a_vld_ff;
         q_vld_ff <= {q_vld_ff[SQ_STEPS-1:0], b_vld_ff};
         e_vld_ff <= q_vld_ff[SQ_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      a_dx_ff      <= wx;
      a_dy_ff      <= wy;
      a_addr_ff    <= cnt_ff[ADDR_W-1:0];
      a_map_ff     <= ({1'b0, ix} < w_eff) && ({1'b0, iy} < h_eff);
      b_dx2_ff     <= sq_x[33:0];
      b_dy2_ff     <= sq_y[33:0];
      b_addr_ff    <= a_addr_ff;
      b_map_ff     <= a_map_ff;
      q_v_ff[0]    <= SQ_W'(d2);
      q_r_ff[0]    <= '0;
      q_addr_ff[0] <= b_addr_ff;
      q_in_ff[0]   <= d2 < 35'(r2_ff);
      q_map_ff[0]  <= b_map_ff;
   end

   // one result bit per stage
   for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
      localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * (SQ_STEPS - i));
      logic [SQ_W-1:0] trial;
      assign trial = q_r_ff[i-1] + SQ_BIT;
      always_ff @(posedge clock) begin
         if (q_v_ff[i-1] >= trial) begin
            q_v_ff[i] <= q_v_ff[i-1] - trial;
            q_r_ff[i] <= (q_r_ff[i-1] >> 1) + SQ_BIT;
         end else begin
            q_v_ff[i] <= q_v_ff[i-1];
            q_r_ff[i] <= q_r_ff[i-1] >> 1;
         end
         q_addr_ff[i] <= q_addr_ff[i-1];
         q_in_ff[i]   <= q_in_ff[i-1];
         q_map_ff[i]  <= q_map_ff[i-1];
      end
   end

   always_comb begin
      sqrt_val = q_r_ff[SQ_STEPS][17:0];
      rim_d    = $signed({1'b0, sqrt_val}) - $signed({4'b0000, radius_ff});
      rim      = rim_d[18] ? 18'(-rim_d) : 18'(rim_d);
      amt      = (rim < {2'b00, thr_q}) ? rim[15:0] : thr_q;
   end

   always_ff @(posedge clock) begin
      e_amt_ff  <= amt;
      e_addr_ff <= q_addr_ff[SQ_STEPS];
      e_in_ff   <= q_in_ff[SQ_STEPS];
      e_map_ff  <= q_map_ff[SQ_STEPS];
   end

   // read-modify-write of one cell
   logic signed [25:0] hv, top_q, bot_q;
   always_comb begin
      top_q = 26'($signed({ceiling_ff, {FRAC_BITS{1'b0}}}));
      bot_q = 26'($signed({floor_ff, {FRAC_BITS{1'b0}}}));
      if (e_in_ff ^ lower_ff) begin
         hv = 26'($signed(mem_rd_ff)) + $signed({10'b0, e_amt_ff});
      end else begin
         hv = 26'($signed(mem_rd_ff)) - $signed({10'b0, e_amt_ff});
      end
      if (e_in_ff) begin
         if (hv > top_q) hv = top_q;
      end else begin
         if (hv < bot_q) hv = bot_q;
      end
      if (hv > 26'sd8388607) begin
         upd_data = 24'h7FFFFF;
      end else if (hv < -26'sd8388608) begin
         upd_data = 24'h800000;
      end else begin
         upd_data = hv[23:0];
      end
   end

   assign busy   = a_vld_ff || b_vld_ff || (|q_vld_ff) || e_vld_ff;
   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT:   if (cnt_ff[ADDR_W-1:0] == '1) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_FAULT: state_in = S_SETUP;
                  FUNC_READ:  state_in = S_READ;
                  FUNC_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR:  if (cnt_ff[ADDR_W-1:0] == '1) state_in = S_DONE;
         S_READ:   state_in = S_RDATA;
         S_RDATA:  state_in = S_DONE;
         S_SETUP:  state_in = S_SETUP2;
         S_SETUP2: state_in = S_SCAN;
         S_SCAN:   if (cnt_ff[16]) state_in = S_DRAIN;
         S_DRAIN:  if (!busy) state_in = S_DONE;
         S_DONE:   if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the control
   always_comb begin
      req_stall     = (state_ff != S_IDLE);
      issue         = 1'b0;
      ld_rsp        = 1'b0;
      cnt_in        = cnt_ff;
      mem_we        = e_vld_ff && e_map_ff;
      mem_waddr     = e_addr_ff;
      mem_wdata     = upd_data;
      mem_raddr     = q_addr_ff[SQ_STEPS];
      res_status_in = res_status_ff;
      res_height_in = res_height_ff;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[ADDR_W-1:0];
            mem_wdata = '0;
            cnt_in    = cnt_ff + 17'd1;
         end
         S_IDLE: begin
            cnt_in        = '0;
            res_height_in = '0;
            unique case (req_func)
               FUNC_FAULT: res_status_in = STATUS_FAULT;
               FUNC_READ:  res_status_in = STATUS_READ;
               FUNC_CLEAR: res_status_in = STATUS_CLEAR;
               default:    res_status_in = STATUS_IGNORED;
            endcase
         end
         S_READ:   mem_raddr = {ry_ff, rx_ff};
         S_RDATA: begin
            if (({1'b0, rx_ff} < w_eff) && ({1'b0, ry_ff} < h_eff)) begin
               res_height_in = mem_rd_ff;
            end
         end
         S_SCAN: begin
            issue = !cnt_ff[16];
            if (!cnt_ff[16]) cnt_in = cnt_ff + 17'd1;
         end
         S_DONE:   ld_rsp = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
      rsp_valid_in = ld_rsp || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_height_ff <= res_height_in;
      if (ld_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_height_ff <= res_height_ff;
      end
      if (accept) begin
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         lower_ff <= req_lower_inside;
         rx_ff    <= req_cell_x;
         ry_ff    <= req_cell_y;
      end
      // radius = floor((min << frac) / 3) by reciprocal
      if (state_ff == S_SETUP) begin
         radius_ff <= r_prod[RECIP_SH+14:RECIP_SH];
      end
      if (state_ff == S_SETUP2) begin
         r2_ff    <= radius_ff * radius_ff;
         limit_ff <= 18'(radius_ff) + 18'(thr_q);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_height = rsp_height_ff;

endmodule

`default_nettype wire

FILE: hdl/cfhu_checker.sv
// ----------------------------------------------------------------------------
// cfhu_checker
// port-level checks of the circular fault height map block
// ----------------------------------------------------------------------------
`default_nettype none

module cfhu_checker import cfhu_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [1:0]          rsp_status,
   input logic signed [23:0]  rsp_height
);

   // store is swept clean after reset before any transaction
   a_init_busy: assert property (@(posedge clock) (!reset && $past(reset)) |-> req_stall)
      else $error("request taken during reset sweep");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction taken while busy");

   a_height_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_READ)) |-> (rsp_height == 24'sd0))
      else $error("nonzero height outside a read");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) && $stable(rsp_height)))
      else $error("stalled result changed");

endmodule

bind circular_fault_heightmap_update cfhu_checker u_cfhu_checker (.*);

`default_nettype wire
